FILE: rtl/pbms_pkg.sv
`timescale 1ns / 1ps
package pbms_pkg;

  localparam int PIXEL_COUNT = 65536;
  localparam int IDX_W = $clog2(PIXEL_COUNT);
  localparam int MAX_TRAINING_FRAMES = 64;
  localparam int DIV_W = 7;
  localparam int SUM_W = 14;
  localparam int DEV_W = 39;
  localparam int NUM_W = 40;
  localparam int ROOT_W = NUM_W / 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [DEV_W-1:0] DEV_MAX = '1;

  localparam logic [0:0] REG_THRESHOLD = 1'd0;
  localparam logic [0:0] REG_FRAMES = 1'd1;
  localparam logic [3:0] THRESHOLD_RESET = 4'd7;
  localparam logic [6:0] FRAMES_RESET = 7'd50;

  typedef enum logic [1:0] {
    OP_ACC = 2'd0,
    OP_DEV = 2'd1,
    OP_FIN = 2'd2,
    OP_DET = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       gray;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

FILE: rtl/pbms_in_if.sv
`timescale 1ns / 1ps
interface pbms_in_if;
  import pbms_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] pixel_index;
  logic [7:0]       gray_value;
  modport source (output valid, opcode, pixel_index, gray_value, input ready);
  modport sink (input valid, opcode, pixel_index, gray_value, output ready);
endinterface

FILE: rtl/pbms_out_if.sv
`timescale 1ns / 1ps
interface pbms_out_if;
  import pbms_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic             foreground;
  modport source (output valid, result_index, foreground, input ready);
  modport sink (input valid, result_index, foreground, output ready);
endinterface

FILE: rtl/pbms_front.sv
`timescale 1ns / 1ps
module pbms_front
  import pbms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pbms_in_if.sink    pixels,
  input  logic       clearing,
  input  logic       pop,
  output head_t      head
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        op_dec;

  // classify the opcode
  always_comb begin
    case (pixels.opcode)
      OP_ACC:  op_dec = OP_ACC;
      OP_DEV:  op_dec = OP_DEV;
      OP_FIN:  op_dec = OP_FIN;
      default: op_dec = OP_DET;
    endcase
  end

  assign pixels.ready = (count != 2'd2) && !clearing;
  assign push = pixels.valid && pixels.ready;
  assign head.valid = (count != 2'd0);
  assign head.item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: op_dec, idx: pixels.pixel_index, gray: pixels.gray_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/pbms_div.sv
`timescale 1ns / 1ps
module pbms_div
  import pbms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [3:0]       cycles,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] num;
  logic [DIV_W-1:0] rem;
  logic [3:0]       cnt;
  logic             busy;
  logic [DIV_W-1:0] rem_next;
  logic [3:0]       qbits;

  // four restoring steps per cycle, most significant bits first
  always_comb begin
    logic [DIV_W:0] t;
    rem_next = rem;
    qbits = '0;
    for (int i = 0; i < 4; i++) begin
      t = {rem_next, num[NUM_W-1-i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        qbits[3-i] = 1'b1;
      end
      rem_next = t[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !start && busy && (cnt == 4'd1);
      if (start) begin
        busy <= 1'b1;
        cnt <= cycles;
        num <= numer;
        rem <= '0;
        quot <= '0;
      end else if (busy) begin
        num <= {num[NUM_W-5:0], 4'b0};
        rem <= rem_next;
        quot <= {quot[NUM_W-5:0], qbits};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/pbms_sqrt.sv
`timescale 1ns / 1ps
module pbms_sqrt
  import pbms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [NUM_W-1:0] val;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             ge;

  // one result bit per cycle, two radicand bits brought down
  assign rem2 = {rem, val[NUM_W-1 -: 2]};
  assign trial = {2'b0, root, 2'b01};
  assign ge = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(ROOT_W);
        val <= value;
        rem <= '0;
        root <= '0;
      end else if (busy) begin
        val <= {val[NUM_W-3:0], 2'b0};
        rem <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
        root <= {root[ROOT_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/pbms_back.sv
`timescale 1ns / 1ps
module pbms_back
  import pbms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  head_t            head,
  output logic             pop,
  output logic             clearing,
  input  logic [DIV_W-1:0] divisor,
  input  logic [3:0]       threshold,
  pbms_out_if.source       results
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MEAN_WAIT, S_SQUARE, S_ACCUM, S_VAR_WAIT, S_ROOT_WAIT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_addr;
  item_t            cur;
  logic [SUM_W-1:0] ps_rd;
  logic [DEV_W-1:0] dev_rd;
  logic [15:0]      ms_rd;
  logic [15:0]      diff;
  logic [31:0]      sq;
  logic [7:0]       mean8;
  logic             out_valid;
  logic [IDX_W-1:0] out_idx;
  logic             out_fg;

  logic [SUM_W-1:0] pixel_sum_mem [PIXEL_COUNT];
  logic [DEV_W-1:0] deviation_sum_mem [PIXEL_COUNT];
  logic [15:0]      mean_spread_mem [PIXEL_COUNT];

  logic             ps_we, dev_we, ms_we;
  logic [IDX_W-1:0] wr_addr;
  logic [SUM_W-1:0] ps_wd;
  logic [DEV_W-1:0] dev_wd;
  logic [15:0]      ms_wd;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_numer, div_quot;
  logic [3:0]       div_cycles;
  logic             sq_start, sq_done;
  logic [ROOT_W-1:0] root;

  logic [5:0]       half;
  logic [SUM_W:0]   sum_add;
  logic [15:0]      mq;
  logic [15:0]      gq;
  logic [7:0]       ad;
  logic [11:0]      limit;
  logic [NUM_W-1:0] acc;
  logic [ROOT_W:0]  sp_wide;
  logic [7:0]       spread;
  logic             out_free;
  logic             det_fire;

  assign half = divisor[DIV_W-1:1];
  assign clearing = (state == S_CLEAR);
  assign out_free = !out_valid || results.ready;
  assign pop = (state == S_IDLE) && head.valid;
  assign det_fire = (state == S_EXEC) && (cur.op == OP_DET) && out_free;

  assign sum_add = {1'b0, ps_rd} + {{(SUM_W-7){1'b0}}, cur.gray};
  assign mq = (div_quot > NUM_W'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
  assign gq = {cur.gray, 8'b0};
  assign ad = (cur.gray >= ms_rd[15:8]) ? cur.gray - ms_rd[15:8] : ms_rd[15:8] - cur.gray;
  assign limit = {8'b0, threshold} * {4'b0, ms_rd[7:0]};
  assign acc = {1'b0, dev_rd} + {{(NUM_W-32){1'b0}}, sq};
  assign sp_wide = ({1'b0, root} + (ROOT_W+1)'(128)) >> 8;
  assign spread = (sp_wide > (ROOT_W+1)'(255)) ? 8'hFF : sp_wide[7:0];

  // memory write side
  always_comb begin
    ps_we = 1'b0;
    dev_we = 1'b0;
    ms_we = 1'b0;
    wr_addr = cur.idx;
    ps_wd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    dev_wd = acc[NUM_W-1] ? DEV_MAX : acc[DEV_W-1:0];
    ms_wd = {mean8, spread};
    case (state)
      S_CLEAR: begin
        ps_we = 1'b1;
        dev_we = 1'b1;
        wr_addr = clr_addr;
        ps_wd = '0;
        dev_wd = '0;
      end
      S_EXEC:      ps_we = (cur.op == OP_ACC);
      S_ACCUM:     dev_we = 1'b1;
      S_ROOT_WAIT: ms_we = sq_done;
      default: ;
    endcase
  end

  // divider and root start
  always_comb begin
    div_start = 1'b0;
    div_numer = '0;
    div_cycles = 4'd0;
    sq_start = (state == S_VAR_WAIT) && div_done;
    if (state == S_EXEC && cur.op == OP_DEV) begin
      div_start = 1'b1;
      div_numer = {NUM_W'({ps_rd, 8'b0}) + NUM_W'(half)} << 16;
      div_cycles = 4'd6;
    end else if (state == S_EXEC && cur.op == OP_FIN) begin
      div_start = 1'b1;
      div_numer = {NUM_W'(ps_rd) + NUM_W'(half)} << 24;
      div_cycles = 4'd4;
    end else if (state == S_MEAN_WAIT && div_done && cur.op == OP_FIN) begin
      div_start = 1'b1;
      div_numer = NUM_W'(dev_rd) + NUM_W'(half);
      div_cycles = 4'd10;
    end
  end

  always_ff @(posedge clk) begin
    if (ps_we) pixel_sum_mem[wr_addr] <= ps_wd;
    if (dev_we) deviation_sum_mem[wr_addr] <= dev_wd;
    if (ms_we) mean_spread_mem[wr_addr] <= ms_wd;
    if (pop) begin
      ps_rd <= pixel_sum_mem[head.item.idx];
      dev_rd <= deviation_sum_mem[head.item.idx];
      ms_rd <= mean_spread_mem[head.item.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (det_fire) out_valid <= 1'b1;
      else if (out_valid && results.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(PIXEL_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cur.op)
            OP_ACC: state <= S_IDLE;
            OP_DET: begin
              if (out_free) begin
                out_idx <= cur.idx;
                out_fg <= {4'b0, ad} > limit;
                state <= S_IDLE;
              end
            end
            default: state <= S_MEAN_WAIT;
          endcase
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            if (cur.op == OP_DEV) begin
              diff <= (gq >= mq) ? gq - mq : mq - gq;
              state <= S_SQUARE;
            end else begin
              mean8 <= (div_quot > NUM_W'(255)) ? 8'hFF : div_quot[7:0];
              state <= S_VAR_WAIT;
            end
          end
        end
        S_SQUARE: begin
          sq <= {16'b0, diff} * {16'b0, diff};
          state <= S_ACCUM;
        end
        S_ACCUM: state <= S_IDLE;
        S_VAR_WAIT: if (div_done) state <= S_ROOT_WAIT;
        S_ROOT_WAIT: if (sq_done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid = out_valid;
  assign results.result_index = out_idx;
  assign results.foreground = out_fg;

  pbms_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_numer), .cycles(div_cycles),
    .divisor(divisor), .done(div_done), .quot(div_quot)
  );

  pbms_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(div_quot), .done(sq_done), .root(root)
  );

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MEAN_WAIT || state == S_VAR_WAIT))
    else $error("divider finished with no one waiting");
  a_root_done_waited: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_ROOT_WAIT)
    else $error("square root finished with no one waiting");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !pop && !out_valid)
    else $error("item taken during clearing pass");
  a_exec_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_EXEC)
    else $error("popped item not executed");
`endif

endmodule

FILE: rtl/pixel_background_model_subtractor_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                               Transfer
// pixels    in   opcode, pixel_index, gray_value       valid && ready
// results   out  result_index, foreground              valid && ready
// cfg       in   cfg_index, cfg_data                   cfg_write
//
// Deviation and finalize run on the shared 4-bit-per-cycle divider, and finalize then
// runs the 1-bit-per-cycle root; accumulate and detect use neither.
// After reset a clearing pass over all 65536 addresses zeroes both sum memories; pixels.ready
// stays low meanwhile. A two-entry queue takes new pixels while the back end works,
// and a result register lets the back end go on while a result waits.
module pixel_background_model_subtractor_core
  import pbms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pbms_in_if.sink    pixels,
  pbms_out_if.source results,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic [3:0]       threshold;
  logic [6:0]       frames;
  logic [DIV_W-1:0] divisor;
  head_t            head;
  logic             pop;
  logic             clearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      frames <= FRAMES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[3:0];
        REG_FRAMES:    frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp divisor into 1..max
  always_comb begin
    if (frames == 7'd0) divisor = DIV_W'(1);
    else if (frames > 7'(MAX_TRAINING_FRAMES)) divisor = DIV_W'(MAX_TRAINING_FRAMES);
    else divisor = frames;
  end

  pbms_front u_front (
    .clk(clk), .rst(rst), .pixels(pixels), .clearing(clearing), .pop(pop), .head(head)
  );

  pbms_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .clearing(clearing),
    .divisor(divisor), .threshold(threshold), .results(results)
  );

endmodule

FILE: tb/tb_pixel_background_model_subtractor_core.sv
`timescale 1ns / 1ps
module tb_pixel_background_model_subtractor_core;
  import pbms_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int SETTLE_CYCLES = 120;  // lets a finalize and the two items queued behind it finish

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             fg;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = REG_THRESHOLD;
  logic [6:0] cfg_data = '0;

  pbms_in_if  pix_if ();
  pbms_out_if res_if ();

  pixel_background_model_subtractor_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pix_if.sink),
    .results  (res_if.source),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state: sums default to zero as after the clearing pass.
  logic [SUM_W-1:0] acc_sum   [int];
  logic [DEV_W-1:0] dev_sum   [int];
  logic [15:0]      model_ms  [int];
  int               finalized [$];
  logic [3:0]       thr_mult = THRESHOLD_RESET;
  logic [6:0]       frames   = FRAMES_RESET;

  verdict_t verdicts[$];

  int  n_items = 0;
  int  n_results = 0;
  int  n_cfg_phases = 0;
  int  n_errors = 0;
  int  cycles = 0;
  bit  steady = 1'b0;      // no random idling on either side while set
  int  park_cycles = 0;    // long receiver hold-off requested by a test

  initial begin
    pix_if.valid = 1'b0;
    pix_if.opcode = OP_ACC;
    pix_if.pixel_index = '0;
    pix_if.gray_value = '0;
    res_if.ready = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    // Mostly short gaps, now and then a long one.
    if ($urandom_range(15, 0) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic longint unsigned eff_div();
    if (frames == 0) return 1;
    if (frames > MAX_TRAINING_FRAMES) return MAX_TRAINING_FRAMES;
    return frames;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Advance the per-pixel model by one accepted transfer.
  task automatic predict_pixel(op_t op, int idx, logic [7:0] gray);
    longint unsigned d, s, m, g, diff, acc, vr, sp;
    verdict_t v;
    int ad;
    d = eff_div();
    s = acc_sum.exists(idx) ? acc_sum[idx] : 0;
    acc = dev_sum.exists(idx) ? dev_sum[idx] : 0;
    case (op)
      OP_ACC: begin
        s = s + gray;
        acc_sum[idx] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
      end
      OP_DEV: begin
        m = ((s << 8) + d / 2) / d;
        if (m > 65535) m = 65535;
        g = longint'(gray) << 8;
        diff = (g >= m) ? g - m : m - g;
        acc = acc + diff * diff;
        dev_sum[idx] = (acc > DEV_MAX) ? DEV_MAX : acc[DEV_W-1:0];
      end
      OP_FIN: begin
        m = (s + d / 2) / d;
        if (m > 255) m = 255;
        vr = (acc + d / 2) / d;
        sp = (floor_root(vr) + 128) >> 8;
        if (sp > 255) sp = 255;
        model_ms[idx] = {m[7:0], sp[7:0]};
        if (finalized.size() == 0 || !(idx inside {finalized})) finalized.push_back(idx);
      end
      default: begin
        ad = int'(gray) - int'(model_ms[idx][15:8]);
        if (ad < 0) ad = -ad;
        v.idx = idx;
        v.fg = ad > int'(thr_mult) * int'(model_ms[idx][7:0]);
        verdicts.push_back(v);
      end
    endcase
  endtask

  // Offer one pixel item, hold it until the transfer, then maybe idle.
  task automatic send_pixel(op_t op, int idx, logic [7:0] gray);
    int gap;
    pix_if.valid <= 1'b1;
    pix_if.opcode <= op;
    pix_if.pixel_index <= idx[IDX_W-1:0];
    pix_if.gray_value <= gray;
    do @(posedge clk); while (!pix_if.ready);
    predict_pixel(op, idx, gray);
    n_items++;
    gap = (steady || $urandom_range(2, 0) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    int stall_left;
    if (park_cycles > 0) begin
      stall_left = park_cycles;
      park_cycles = 0;
    end
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(7, 0) == 0) begin
      stall_left = gap_len() - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each result transfer against the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && res_if.valid && res_if.ready) begin
      n_results++;
      if (verdicts.size() == 0) begin
        $error("unexpected result: result_index %0d foreground %0d",
               res_if.result_index, res_if.foreground);
        n_errors++;
      end else begin
        v = verdicts.pop_front();
        if (res_if.result_index !== v.idx) begin
          $error("result_index: expected %0d actual %0d", v.idx, res_if.result_index);
          n_errors++;
        end
        if (res_if.foreground !== v.fg) begin
          $error("foreground: expected %0d actual %0d", v.fg, res_if.foreground);
          n_errors++;
        end
      end
    end
  end

  // Drop valid, wait for every verdict, then let the back end settle.
  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [6:0] thr, logic [6:0] frm);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    thr_mult = thr[3:0];
    cfg_index <= REG_FRAMES;
    cfg_data <= frm;
    @(posedge clk);
    frames = frm;
    cfg_write <= 1'b0;
    n_cfg_phases++;
  endtask

  function automatic int pick_finalized();
    return finalized[$urandom_range(finalized.size() - 1, 0)];
  endfunction

  // Train one pixel for a few frames, finalize it, then run detections on it.
  task automatic train_pixel(int idx, int n, int n_det);
    int base;
    int spread;
    base = $urandom_range(255, 0);
    spread = $urandom_range(40, 0);
    for (int i = 0; i < n; i++)
      send_pixel(OP_ACC, idx, 8'(base + $urandom_range(spread, 0)));
    for (int i = 0; i < n; i++)
      send_pixel(OP_DEV, idx, 8'(base + $urandom_range(spread, 0)));
    send_pixel(OP_FIN, idx, 8'($urandom_range(255, 0)));
    for (int i = 0; i < n_det; i++)
      send_pixel(OP_DET, idx, (i % 4 == 0) ? 8'(base + spread / 2) : 8'($urandom_range(255, 0)));
  endtask

  task automatic test_directed();
    steady = 1'b1;
    send_pixel(OP_ACC, 0, 8'd255);
    send_pixel(OP_ACC, 65535, 8'd0);
    send_pixel(OP_ACC, 1, 8'd128);
    send_pixel(OP_ACC, 1, 8'd200);
    send_pixel(OP_DEV, 0, 8'd0);
    send_pixel(OP_DEV, 65535, 8'd255);
    send_pixel(OP_DEV, 1, 8'd100);
    send_pixel(OP_DEV, 1, 8'd255);
    send_pixel(OP_FIN, 0, 8'd0);
    send_pixel(OP_FIN, 65535, 8'd255);
    send_pixel(OP_FIN, 1, 8'd0);
    send_pixel(OP_DET, 0, 8'd0);
    send_pixel(OP_DET, 0, 8'd255);
    send_pixel(OP_DET, 65535, 8'd255);
    send_pixel(OP_DET, 65535, 8'd0);
    send_pixel(OP_DET, 1, 8'd128);
    send_pixel(OP_DET, 1, 8'd0);
    send_pixel(OP_DET, 1, 8'd255);
    // Detect on a pixel trained only by deviation passes (sum still zero).
    send_pixel(OP_DEV, 2, 8'd255);
    send_pixel(OP_FIN, 2, 8'd0);
    send_pixel(OP_DET, 2, 8'd1);
    steady = 1'b0;
  endtask

  // Saturate both sums: divisor 1 keeps the mean at its ceiling.
  task automatic test_saturation();
    write_regs(7'd1, 7'd1);
    for (int i = 0; i < 70; i++) send_pixel(OP_ACC, 4660, 8'd255);
    for (int i = 0; i < 132; i++) send_pixel(OP_DEV, 4660, 8'd0);
    send_pixel(OP_FIN, 4660, 8'd0);
    send_pixel(OP_DET, 4660, 8'd0);
    send_pixel(OP_DET, 4660, 8'd255);
  endtask

  // Walk the register extremes, including a zero divisor and one above the cap.
  task automatic test_config_sweep();
    logic [6:0] thr_set[6] = '{7'd0, 7'd15, 7'd1, 7'd15, 7'd3, 7'd127};
    logic [6:0] frm_set[6] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd50};
    for (int k = 0; k < 6; k++) begin
      write_regs(thr_set[k], frm_set[k]);
      for (int p = 0; p < 3; p++)
        train_pixel($urandom_range(65535, 0), $urandom_range(8, 1), 3);
    end
  endtask

  // Park the receiver while detections keep coming so the input backs up.
  task automatic test_backpressure();
    drain();
    park_cycles = 400;
    steady = 1'b1;
    for (int i = 0; i < 40; i++)
      send_pixel(OP_DET, pick_finalized(), 8'($urandom_range(255, 0)));
    steady = 1'b0;
  endtask

  task automatic test_random();
    int pool[16];
    int start;
    int op;
    int idx;
    start = n_items;
    while (n_items - start < RANDOM_ITEMS) begin
      write_regs(7'($urandom_range(15, 0)), 7'($urandom_range(127, 0)));
      foreach (pool[i]) pool[i] = $urandom_range(65535, 0);
      steady = ($urandom_range(3, 0) == 0);
      repeat (20) begin
        if ($urandom_range(9, 0) < 7) begin
          train_pixel(pool[$urandom_range(15, 0)], $urandom_range(6, 1), $urandom_range(5, 1));
        end else begin
          // Noise: stray operations anywhere; detect only where a model exists.
          op = $urandom_range(3, 0);
          idx = $urandom_range(65535, 0);
          if (op == OP_DET) idx = pick_finalized();
          send_pixel(op_t'(op), idx, 8'($urandom_range(255, 0)));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d pixel items, checked %0d detection results over %0d register settings,",
             n_items, n_results, n_cfg_phases);
    $display("including sum saturation, zero and oversize divisors and a long output stall.");
    if (n_errors == 0 && verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
